// ===== sv/ftff_pkg.sv =====
package ftff_pkg;

    localparam int MAX_TAPS_DEF   = 4;
    localparam int MAX_PIXELS_DEF = 4096;

    localparam int NUM_COEFS = 4;
    localparam int PIX_W     = 16;
    localparam int COEF_W    = 16;
    localparam int OUT_W     = 21;
    localparam int TAPCNT_W  = 3;
    localparam int FRAC_BITS = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP3 = 3'd4;

    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 3'd1;
    localparam logic [COEF_W-1:0]   COEF0_RST     = 16'd4096;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 21'sh0FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 21'sh100000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_value;
        logic                    frame_end;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered_value;
        logic                    frame_end_out;
    } t_out_item;

endpackage

// ===== sv/frame_temporal_fir_filter.sv =====
// Temporal FIR filter over a stream of image frames.
// Input channel (i_in_valid / o_in_ready, i_in_item): one pixel per transaction
// in raster order, frame_end set on the last pixel of a frame. Output channel
// (o_out_valid / i_out_ready, o_out_item): one filtered pixel per input pixel,
// in order, frame_end_out copied from the input.
// Each pixel is stored into the current frame slot of a single-port frame
// store, then one store read and one multiply-accumulate are done per tap, one
// tap per cycle, the read of tap k+1 overlapping the accumulate of tap k.
// A new pixel is accepted only once the previous one has been loaded into the
// output register: the store port and the single multiplier serve one pixel
// at a time.
// The output register holds a finished result while the receiver stalls; the
// next pixel is accepted and processed meanwhile and waits in the final step
// until that register is free.
// Reset empties the ring by clearing a per-slot fill count (entries beyond it
// read as zero), so no clearing pass is needed; the block is ready right after
// reset. Configuration writes (i_cfg_wr_en, i_cfg_index, i_cfg_wdata) take
// effect at once and are meant for idle periods only.
module frame_temporal_fir_filter #(
    parameter int MAX_TAPS   = ftff_pkg::MAX_TAPS_DEF,
    parameter int MAX_PIXELS = ftff_pkg::MAX_PIXELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ftff_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ftff_pkg::CFG_DAT_W-1:0]      i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ftff_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ftff_pkg::t_out_item                 o_out_item
);
    import ftff_pkg::*;

    localparam int SW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int KW    = $clog2(MAX_TAPS + 1);
    localparam int PW    = $clog2(MAX_PIXELS);
    localparam int CW    = $clog2(MAX_PIXELS + 1);
    localparam int DEPTH = MAX_TAPS * MAX_PIXELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = 2 * PIX_W + KW + 1;

    t_state r_state, n_state;

    logic [TAPCNT_W-1:0]     r_tap_count;
    logic signed [COEF_W-1:0] r_coef [NUM_COEFS];

    logic [SW-1:0] r_slot;
    logic [PW-1:0] r_pos;
    logic [CW-1:0] r_fill [MAX_TAPS];
    logic          r_last;

    logic [KW-1:0]              r_k;
    logic                       r_rd_vld;
    logic                       r_rd_live;
    logic signed [COEF_W-1:0]   r_rd_coef;
    logic signed [PIX_W-1:0]    r_rd_data;
    logic signed [ACC_W-1:0]    r_acc;

    logic      r_out_valid;
    t_out_item r_out_item;

    logic [PIX_W-1:0] mem [DEPTH];

    logic [KW-1:0]            eff_taps;
    logic [KW-1:0]            slot_ext;
    logic [KW-1:0]            back_slot;
    logic [SW-1:0]            slot_k;
    logic [SW-1:0]            fill_slot;
    logic [CW-1:0]            fill_cur;
    logic [CW-1:0]            pos_ext;
    logic [AW-1:0]            mem_addr;
    logic signed [COEF_W-1:0] coef_k;
    logic                     in_accept;
    logic                     issue;
    logic                     run_done;
    logic                     out_load;
    logic signed [ACC_W-1:0]  acc_q;
    logic signed [OUT_W-1:0]  sat_q;
    logic signed [2*PIX_W-1:0] product;

    // effective tap count: zero acts as one, large values clamp
    always_comb begin
        if (r_tap_count == '0) begin
            eff_taps = KW'(1);
        end else if (int'(r_tap_count) > MAX_TAPS) begin
            eff_taps = KW'(MAX_TAPS);
        end else begin
            eff_taps = KW'(r_tap_count);
        end
    end

    // step backward around the ring, wrapping at the effective tap count
    always_comb begin
        slot_ext = KW'(r_slot);
        if (slot_ext >= r_k) begin
            back_slot = slot_ext - r_k;
        end else begin
            back_slot = slot_ext + eff_taps - r_k;
        end
        slot_k = back_slot[SW-1:0];
    end

    always_comb begin
        coef_k = '0;
        for (int i = 0; i < NUM_COEFS; i++) begin
            if (int'(r_k) == i) begin
                coef_k = r_coef[i];
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        in_accept  = 1'b0;
        issue      = 1'b0;
        run_done   = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                in_accept  = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                issue    = (r_k < eff_taps);
                run_done = !issue && !r_rd_vld;
                if (run_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                out_load = !r_out_valid || i_out_ready;
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign fill_slot = (r_state == ST_IDLE) ? r_slot : slot_k;
    assign fill_cur  = r_fill[fill_slot];
    assign pos_ext   = CW'(r_pos);
    assign mem_addr  = AW'(fill_slot) * AW'(MAX_PIXELS) + AW'(r_pos);

    // single-port frame store: write on acceptance, reads during the tap walk
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            mem[mem_addr] <= i_in_item.pixel_value;
        end
        r_rd_data <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
            r_coef[0]   <= COEF0_RST;
            for (int i = 1; i < NUM_COEFS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_TAP_COUNT: r_tap_count <= i_cfg_wdata[TAPCNT_W-1:0];
                REG_COEF_TAP0: r_coef[0]   <= i_cfg_wdata;
                REG_COEF_TAP1: r_coef[1]   <= i_cfg_wdata;
                REG_COEF_TAP2: r_coef[2]   <= i_cfg_wdata;
                REG_COEF_TAP3: r_coef[3]   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // fill count per slot: frames are written from position zero upward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (in_accept && (pos_ext >= fill_cur)) begin
            r_fill[r_slot] <= pos_ext + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_pos  <= '0;
        end else if (out_load) begin
            if (r_last) begin
                r_pos <= '0;
                if (KW'(r_slot) + KW'(1) >= eff_taps) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + SW'(1);
                end
            end else if (int'(r_pos) < MAX_PIXELS - 1) begin
                r_pos <= r_pos + PW'(1);
            end
        end
    end

    assign product = r_rd_coef * (r_rd_live ? r_rd_data : PIX_W'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (in_accept) begin
                r_k <= '0;
            end else if (issue) begin
                r_k <= r_k + KW'(1);
            end
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_last <= i_in_item.frame_end;
            r_acc  <= '0;
        end else if (r_rd_vld) begin
            r_acc <= r_acc + ACC_W'(product);
        end
        if (issue) begin
            r_rd_coef <= coef_k;
            r_rd_live <= (pos_ext < fill_cur);
        end
    end

    // floor shift, then saturate to the output range
    always_comb begin
        acc_q = r_acc >>> FRAC_BITS;
        if ((&acc_q[ACC_W-1:OUT_W-1]) || !(|acc_q[ACC_W-1:OUT_W-1])) begin
            sat_q = acc_q[OUT_W-1:0];
        end else if (acc_q[ACC_W-1]) begin
            sat_q = OUT_MIN;
        end else begin
            sat_q = OUT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.filtered_value <= sat_q;
            r_out_item.frame_end_out  <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/ftff_checker.sv =====
module ftff_sva (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input ftff_pkg::t_out_item             o_out_item
);
    import ftff_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    // after taking a pixel, the input is not ready again while that pixel is processed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready ##1 !o_in_ready ##1 !o_in_ready)
        else $error("input taken again too soon after a transaction");

    // a result never appears in the cycle right after acceptance from an empty output
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !o_out_valid |=> !o_out_valid)
        else $error("result shown without processing time");

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("output payload changed while stalled");

endmodule

bind frame_temporal_fir_filter ftff_sva u_ftff_sva (.*);
